>>> sv/echo_distance_led_indicator_macros.svh
// Assertion macros shared by the echo distance indicator RTL
`ifndef ECHO_DISTANCE_LED_INDICATOR_MACROS_SVH
`define ECHO_DISTANCE_LED_INDICATOR_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define EDLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define EDLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/edli_pkg.sv
// Shared constants, types and register codes for the echo distance indicator
`default_nettype none

package edli_pkg;

  // Pulse timing
  localparam int unsigned TICK_CYCLES = 256;
  localparam int unsigned COUNT_BITS  = 20;
  localparam int unsigned CNT_W       = $clog2(COUNT_BITS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] TICK_STEP = COUNT_BITS'(TICK_CYCLES);

  // Field widths
  localparam int unsigned CM_W    = 12;
  localparam int unsigned HOLD_W  = 10;
  localparam int unsigned LVL_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned PREV_W  = 13;
  localparam int unsigned WIN_W   = 4;

  // Movement window limits
  localparam logic [WIN_W-1:0] WIN_MIN  = 4'd2;
  localparam logic [WIN_W-1:0] WIN_CAP  = 4'd8;
  localparam logic [WIN_W-1:0] WIN_WIDE = 4'd10;

  // Colour intensities
  localparam logic [LVL_W-1:0] LVL_OFF      = 8'd0;
  localparam logic [LVL_W-1:0] LVL_FULL     = 8'd255;
  localparam logic [LVL_W-1:0] LVL_AMBER_G  = 8'd100;
  localparam logic [LVL_W-1:0] LVL_GREEN    = 8'd220;
  localparam logic [LVL_W-1:0] LVL_CYAN     = 8'd60;
  localparam logic [LVL_W-1:0] LVL_DIM_BLUE = 8'd40;
  localparam logic [LVL_W-1:0] LVL_READY    = 8'd1;

  // Register reset values
  localparam logic [CM_W-1:0]   RST_CYCLES_PER_CM = 12'd472;
  localparam logic [HOLD_W-1:0] RST_HOLD_LIMIT    = 10'd600;
  localparam logic [CM_W-1:0]   RST_BLINK_CM      = 12'd6;
  localparam logic [CM_W-1:0]   RST_RED_CM        = 12'd12;
  localparam logic [CM_W-1:0]   RST_YELLOW_CM     = 12'd26;
  localparam logic [CM_W-1:0]   RST_GREEN_CM      = 12'd80;
  localparam logic [CM_W-1:0]   RST_CYAN_CM       = 12'd150;

  // Input function codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLES_PER_CM = 3'd0,
    REG_HOLD_LIMIT    = 3'd1,
    REG_BLINK_CM      = 3'd2,
    REG_RED_CM        = 3'd3,
    REG_YELLOW_CM     = 3'd4,
    REG_GREEN_CM      = 3'd5,
    REG_CYAN_CM       = 3'd6
  } cfg_reg_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> sv/edli_in_if.sv
// Input channel: echo events and timer ticks
`default_nettype none

interface edli_in_if;
  logic valid;
  logic ready;
  logic func;
  logic echo_level;

  modport source (output valid, output func, output echo_level, input ready);
  modport sink (input valid, input func, input echo_level, output ready);
endinterface

`default_nettype wire

>>> sv/edli_out_if.sv
// Result channel: distance and LED intensities
`default_nettype none

interface edli_out_if;
  logic                            valid;
  logic                            ready;
  logic [edli_pkg::CM_W-1:0]       distance_cm;
  logic [edli_pkg::LVL_W-1:0]      red_level;
  logic [edli_pkg::LVL_W-1:0]      green_level;
  logic [edli_pkg::LVL_W-1:0]      blue_level;
  logic                            resting;

  modport source (output valid, output distance_cm, output red_level, output green_level,
                  output blue_level, output resting, input ready);
  modport sink (input valid, input distance_cm, input red_level, input green_level,
                input blue_level, input resting, output ready);
endinterface

`default_nettype wire

>>> sv/echo_distance_led_indicator.sv
// Echo distance LED indicator: pulse timer, serial divider and colour mapping
//
// Usage:
//   in_ch carries one word per event: func 0 is a timer tick that adds 256 to the
//   pulse count, func 1 an echo pin change with its new level in echo_level. Ticks count
//   only while an echo is awaited; a rising edge restarts the count.
//   A falling edge while waiting yields one word on out_ch: distance_cm and the
//   red, green and blue intensities plus the resting flag. Other events give none.
//   Ticks and rising edges leave in_ch ready for the next event. A falling edge
//   starts the bit-serial divider, producing one quotient bit per cycle over the
//   20-bit pulse count, then waits to load out_ch; in_ch is not ready meanwhile.
//   A finished word sits in an output register; further events are accepted
//   while it waits. If the receiver still stalls when the next distance is
//   ready, that distance holds until the register frees.
//   cfg_we writes register cfg_index with cfg_data; write only
//   while no measurement is in flight.
//   Synchronous reset (rst_n low) loads the register defaults, clears the count,
//   forgets the last distance and empties the output register.
`default_nettype none

module echo_distance_led_indicator (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  edli_in_if.sink                                   in_ch,
  edli_out_if.source                                out_ch,
  input  wire logic                                 cfg_we,
  input  wire logic [edli_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [edli_pkg::CFG_DATA_W-1:0]      cfg_data
);

`include "echo_distance_led_indicator_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                              state_r, state_nxt;

  // Configuration registers
  logic [edli_pkg::CM_W-1:0]           cpc_r, blink_cm_r, red_cm_r, yellow_cm_r;
  logic [edli_pkg::CM_W-1:0]           green_cm_r, cyan_cm_r;
  logic [edli_pkg::HOLD_W-1:0]         hold_r;

  // Measurement state
  logic                                awaiting_r, awaiting_nxt;
  logic [edli_pkg::COUNT_BITS-1:0]     pulse_r, pulse_nxt;
  logic [edli_pkg::PREV_W-1:0]         prev_r, prev_nxt;
  logic [edli_pkg::HOLD_W-1:0]         steady_r, steady_nxt;
  logic                                blink_r, blink_nxt;

  // Output register
  logic                                out_valid_r, out_valid_nxt;
  logic [edli_pkg::CM_W-1:0]           out_cm_r, out_cm_nxt;
  logic [edli_pkg::LVL_W-1:0]          out_red_r, out_red_nxt;
  logic [edli_pkg::LVL_W-1:0]          out_grn_r, out_grn_nxt;
  logic [edli_pkg::LVL_W-1:0]          out_blu_r, out_blu_nxt;
  logic                                out_rest_r, out_rest_nxt;

  logic                                in_fire, out_fire, div_start, load_out;
  edli_pkg::div_stat_t                 div_stat;
  logic [edli_pkg::COUNT_BITS-1:0]     quotient;

  logic [edli_pkg::CM_W-1:0]           cm;
  logic [edli_pkg::CM_W-2:0]           half;
  logic [edli_pkg::WIN_W-1:0]          window;
  logic signed [edli_pkg::CM_W+1:0]    diff;
  logic [edli_pkg::CM_W+1:0]           abs_diff;
  logic                                steady;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;
  assign div_start = in_fire && (in_ch.func == edli_pkg::FUNC_EDGE) && !in_ch.echo_level
                     && awaiting_r;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  edli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (pulse_r),
    .divisor  (cpc_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Saturate the quotient and derive the movement window
  always_comb begin
    cm     = (|quotient[edli_pkg::COUNT_BITS-1:edli_pkg::CM_W]) ? '1
             : quotient[edli_pkg::CM_W-1:0];
    half   = cm[edli_pkg::CM_W-1:1];
    if (half < (edli_pkg::CM_W-1)'(edli_pkg::WIN_MIN)) begin
      window = edli_pkg::WIN_MIN;
    end else if (half > (edli_pkg::CM_W-1)'(edli_pkg::WIN_CAP)) begin
      window = edli_pkg::WIN_WIDE;
    end else begin
      window = half[edli_pkg::WIN_W-1:0];
    end
    diff     = $signed({2'b00, cm}) - $signed({prev_r[edli_pkg::PREV_W-1], prev_r});
    abs_diff = diff[edli_pkg::CM_W+1] ? (edli_pkg::CM_W+2)'(-diff)
               : (edli_pkg::CM_W+2)'(diff);
    steady   = (abs_diff <= (edli_pkg::CM_W+2)'(window));
  end

  // Event handling, measurement update and result mapping
  always_comb begin
    state_nxt     = state_r;
    awaiting_nxt  = awaiting_r;
    pulse_nxt     = pulse_r;
    prev_nxt      = prev_r;
    steady_nxt    = steady_r;
    blink_nxt     = blink_r;
    out_valid_nxt = out_valid_r && !out_fire;
    out_cm_nxt    = out_cm_r;
    out_red_nxt   = out_red_r;
    out_grn_nxt   = out_grn_r;
    out_blu_nxt   = out_blu_r;
    out_rest_nxt  = out_rest_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.func == edli_pkg::FUNC_TICK) begin
            // Advance the pulse count, saturating at full scale
            if (awaiting_r) begin
              pulse_nxt = (pulse_r >= edli_pkg::COUNT_MAX - edli_pkg::TICK_STEP)
                          ? edli_pkg::COUNT_MAX : pulse_r + edli_pkg::TICK_STEP;
            end
          end else if (in_ch.echo_level) begin
            pulse_nxt    = '0;
            awaiting_nxt = 1'b1;
          end else if (awaiting_r) begin
            awaiting_nxt = 1'b0;
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_cm_nxt    = cm;
          out_rest_nxt  = 1'b0;
          if (steady && (steady_r >= hold_r)) begin
            // Resting: faint ready light, keep history untouched
            out_red_nxt  = edli_pkg::LVL_OFF;
            out_grn_nxt  = edli_pkg::LVL_OFF;
            out_blu_nxt  = edli_pkg::LVL_READY;
            out_rest_nxt = 1'b1;
          end else begin
            steady_nxt = steady ? steady_r + 1'b1 : '0;
            prev_nxt   = {1'b0, cm};
            if (cm <= blink_cm_r) begin
              out_red_nxt = edli_pkg::LVL_FULL;
              out_grn_nxt = blink_r ? edli_pkg::LVL_FULL : edli_pkg::LVL_OFF;
              out_blu_nxt = blink_r ? edli_pkg::LVL_FULL : edli_pkg::LVL_OFF;
              blink_nxt   = !blink_r;
            end else begin
              blink_nxt = 1'b1;
              if (cm <= red_cm_r) begin
                out_red_nxt = edli_pkg::LVL_FULL;
                out_grn_nxt = edli_pkg::LVL_OFF;
                out_blu_nxt = edli_pkg::LVL_OFF;
              end else if (cm <= yellow_cm_r) begin
                out_red_nxt = edli_pkg::LVL_FULL;
                out_grn_nxt = edli_pkg::LVL_AMBER_G;
                out_blu_nxt = edli_pkg::LVL_OFF;
              end else if (cm <= green_cm_r) begin
                out_red_nxt = edli_pkg::LVL_OFF;
                out_grn_nxt = edli_pkg::LVL_GREEN;
                out_blu_nxt = edli_pkg::LVL_OFF;
              end else if (cm <= cyan_cm_r) begin
                out_red_nxt = edli_pkg::LVL_OFF;
                out_grn_nxt = edli_pkg::LVL_CYAN;
                out_blu_nxt = edli_pkg::LVL_CYAN;
              end else begin
                out_red_nxt = edli_pkg::LVL_OFF;
                out_grn_nxt = edli_pkg::LVL_OFF;
                out_blu_nxt = edli_pkg::LVL_DIM_BLUE;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state, measurement history and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      awaiting_r  <= 1'b0;
      pulse_r     <= '0;
      prev_r      <= '1;
      steady_r    <= '0;
      blink_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      awaiting_r  <= awaiting_nxt;
      pulse_r     <= pulse_nxt;
      prev_r      <= prev_nxt;
      steady_r    <= steady_nxt;
      blink_r     <= blink_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_cm_r   <= out_cm_nxt;
    out_red_r  <= out_red_nxt;
    out_grn_r  <= out_grn_nxt;
    out_blu_r  <= out_blu_nxt;
    out_rest_r <= out_rest_nxt;
  end

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpc_r       <= edli_pkg::RST_CYCLES_PER_CM;
      hold_r      <= edli_pkg::RST_HOLD_LIMIT;
      blink_cm_r  <= edli_pkg::RST_BLINK_CM;
      red_cm_r    <= edli_pkg::RST_RED_CM;
      yellow_cm_r <= edli_pkg::RST_YELLOW_CM;
      green_cm_r  <= edli_pkg::RST_GREEN_CM;
      cyan_cm_r   <= edli_pkg::RST_CYAN_CM;
    end else if (cfg_we) begin
      case (cfg_index)
        edli_pkg::REG_CYCLES_PER_CM: cpc_r       <= cfg_data;
        edli_pkg::REG_HOLD_LIMIT:    hold_r      <= cfg_data[edli_pkg::HOLD_W-1:0];
        edli_pkg::REG_BLINK_CM:      blink_cm_r  <= cfg_data;
        edli_pkg::REG_RED_CM:        red_cm_r    <= cfg_data;
        edli_pkg::REG_YELLOW_CM:     yellow_cm_r <= cfg_data;
        edli_pkg::REG_GREEN_CM:      green_cm_r  <= cfg_data;
        edli_pkg::REG_CYAN_CM:       cyan_cm_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.distance_cm = out_cm_r;
  assign out_ch.red_level   = out_red_r;
  assign out_ch.green_level = out_grn_r;
  assign out_ch.blue_level  = out_blu_r;
  assign out_ch.resting     = out_rest_r;

  `EDLI_ASSERT_NOW(a_done_in_div, div_stat.done, state_r == ST_DIV, "divider done outside division")
  `EDLI_ASSERT_NOW(a_div_clears_wait, state_r == ST_DIV, !awaiting_r && div_stat.busy != div_stat.done || div_stat.done || div_stat.busy, "bad division state")
  `EDLI_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_r, "result word lost on load")
  `EDLI_ASSERT_NOW(a_rest_levels, out_valid_r && out_rest_r, out_red_r == edli_pkg::LVL_OFF && out_grn_r == edli_pkg::LVL_OFF, "resting word shows colour")

endmodule

`default_nettype wire

>>> sv/edli_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
`default_nettype none

module edli_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [edli_pkg::COUNT_BITS-1:0]      dividend,
  input  wire logic [edli_pkg::CM_W-1:0]            divisor,
  output edli_pkg::div_stat_t                       stat,
  output logic      [edli_pkg::COUNT_BITS-1:0]      quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [edli_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [edli_pkg::CM_W-1:0]         rem_r, rem_nxt;
  logic [edli_pkg::COUNT_BITS-1:0]   dq_r, dq_nxt;
  logic [edli_pkg::CM_W:0]           trial;
  logic                              fits;

  // Shift the next dividend bit into the partial remainder and try the divisor
  assign trial = {rem_r, dq_r[edli_pkg::COUNT_BITS-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? edli_pkg::CM_W'(trial - {1'b0, divisor})
                     : edli_pkg::CM_W'(trial);
      dq_nxt  = {dq_r[edli_pkg::COUNT_BITS-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      // Stop after the last quotient bit
      if (cnt_r == edli_pkg::CNT_W'(edli_pkg::COUNT_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

`default_nettype wire

>>> test/edli_reading_checker.sv
// Watches the echo and result channels, predicts each reading and compares it field by field
module edli_reading_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  edli_in_if                                   in_ch,
  edli_out_if                                  out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [edli_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [edli_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                          mismatches,
  output int unsigned                          readings_due
);

  localparam int unsigned CM_LIMIT = (1 << edli_pkg::CM_W) - 1;

  typedef struct packed {
    logic [edli_pkg::CM_W-1:0]  distance_cm;
    logic [edli_pkg::LVL_W-1:0] red;
    logic [edli_pkg::LVL_W-1:0] green;
    logic [edli_pkg::LVL_W-1:0] blue;
    logic                       resting;
  } reading_t;

  reading_t due_q[$];

  // Mirrored registers
  logic [edli_pkg::CM_W-1:0]   per_cm;
  logic [edli_pkg::HOLD_W-1:0] hold_lim;
  logic [edli_pkg::CM_W-1:0]   blink_cm;
  logic [edli_pkg::CM_W-1:0]   red_cm;
  logic [edli_pkg::CM_W-1:0]   yellow_cm;
  logic [edli_pkg::CM_W-1:0]   green_cm;
  logic [edli_pkg::CM_W-1:0]   cyan_cm;

  // Predicted measurement state
  logic                               awaiting;
  logic [edli_pkg::COUNT_BITS-1:0]    pulse;
  logic signed [edli_pkg::PREV_W-1:0] last_cm;
  logic [edli_pkg::HOLD_W-1:0]        steady;
  logic                               blink_white;

  task automatic report(input string msg);
    $display("reading check: %s", msg);
    mismatches++;
  endtask

  function automatic reading_t make_reading(input logic [edli_pkg::CM_W-1:0] cm,
                                            input logic [edli_pkg::LVL_W-1:0] r,
                                            input logic [edli_pkg::LVL_W-1:0] g,
                                            input logic [edli_pkg::LVL_W-1:0] b,
                                            input logic rest);
    reading_t rd;
    rd.distance_cm = cm;
    rd.red         = r;
    rd.green       = g;
    rd.blue        = b;
    rd.resting     = rest;
    return rd;
  endfunction

  // Advance the predictor by one accepted word; a falling edge while waiting queues a reading
  task automatic take_event(input logic f, input logic lvl);
    int unsigned               quot;
    logic [edli_pkg::CM_W-1:0] cm;
    int                        win;
    int                        diff;
    reading_t                  rd;
    if (f == edli_pkg::FUNC_TICK) begin
      if (awaiting) begin
        if (pulse >= edli_pkg::COUNT_MAX - edli_pkg::TICK_STEP) pulse = edli_pkg::COUNT_MAX;
        else pulse = pulse + edli_pkg::TICK_STEP;
      end
    end else if (lvl) begin
      pulse    = '0;
      awaiting = 1'b1;
    end else if (awaiting) begin
      awaiting = 1'b0;
      if (per_cm == '0) quot = CM_LIMIT;
      else quot = 32'(pulse) / 32'(per_cm);
      cm = (quot > CM_LIMIT) ? edli_pkg::CM_W'(CM_LIMIT) : edli_pkg::CM_W'(quot);

      // Movement window: half the distance, floored, wide above the cap
      win = int'(cm >> 1);
      if (win < int'(edli_pkg::WIN_MIN)) win = int'(edli_pkg::WIN_MIN);
      if (win > int'(edli_pkg::WIN_CAP)) win = int'(edli_pkg::WIN_WIDE);
      diff = int'(cm) - int'(last_cm);
      if (diff < 0) diff = -diff;

      if (diff <= win && steady >= hold_lim) begin
        // Resting: keep history, show only the ready light
        rd = make_reading(cm, edli_pkg::LVL_OFF, edli_pkg::LVL_OFF, edli_pkg::LVL_READY, 1'b1);
      end else begin
        if (diff <= win) steady = steady + 1'b1;
        else steady = '0;
        last_cm = {1'b0, cm};
        if (cm <= blink_cm) begin
          if (blink_white)
            rd = make_reading(cm, edli_pkg::LVL_FULL, edli_pkg::LVL_FULL, edli_pkg::LVL_FULL,
                              1'b0);
          else
            rd = make_reading(cm, edli_pkg::LVL_FULL, edli_pkg::LVL_OFF, edli_pkg::LVL_OFF,
                              1'b0);
          blink_white = !blink_white;
        end else begin
          blink_white = 1'b1;
          if (cm <= red_cm)
            rd = make_reading(cm, edli_pkg::LVL_FULL, edli_pkg::LVL_OFF, edli_pkg::LVL_OFF,
                              1'b0);
          else if (cm <= yellow_cm)
            rd = make_reading(cm, edli_pkg::LVL_FULL, edli_pkg::LVL_AMBER_G, edli_pkg::LVL_OFF,
                              1'b0);
          else if (cm <= green_cm)
            rd = make_reading(cm, edli_pkg::LVL_OFF, edli_pkg::LVL_GREEN, edli_pkg::LVL_OFF,
                              1'b0);
          else if (cm <= cyan_cm)
            rd = make_reading(cm, edli_pkg::LVL_OFF, edli_pkg::LVL_CYAN, edli_pkg::LVL_CYAN,
                              1'b0);
          else
            rd = make_reading(cm, edli_pkg::LVL_OFF, edli_pkg::LVL_OFF, edli_pkg::LVL_DIM_BLUE,
                              1'b0);
        end
      end
      due_q.push_back(rd);
    end
  endtask

  // Compare one accepted result word against the oldest predicted reading
  task automatic check_reading();
    reading_t got;
    reading_t want;
    got = {out_ch.distance_cm, out_ch.red_level, out_ch.green_level, out_ch.blue_level,
           out_ch.resting};
    if (due_q.size() == 0) begin
      report($sformatf("unexpected word, distance_cm %0d", got.distance_cm));
    end else begin
      want = due_q.pop_front();
      if (got.distance_cm !== want.distance_cm)
        report($sformatf("distance_cm got %0d want %0d", got.distance_cm, want.distance_cm));
      if (got.red !== want.red)
        report($sformatf("red_level got %0d want %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green_level got %0d want %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue_level got %0d want %0d", got.blue, want.blue));
      if (got.resting !== want.resting)
        report($sformatf("resting got %0b want %0b", got.resting, want.resting));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      per_cm      = edli_pkg::RST_CYCLES_PER_CM;
      hold_lim    = edli_pkg::RST_HOLD_LIMIT;
      blink_cm    = edli_pkg::RST_BLINK_CM;
      red_cm      = edli_pkg::RST_RED_CM;
      yellow_cm   = edli_pkg::RST_YELLOW_CM;
      green_cm    = edli_pkg::RST_GREEN_CM;
      cyan_cm     = edli_pkg::RST_CYAN_CM;
      awaiting    = 1'b0;
      pulse       = '0;
      last_cm     = '1;
      steady      = '0;
      blink_white = 1'b1;
      mismatches  = 0;
      due_q.delete();
    end else begin
      // Mirror register writes
      if (cfg_we) begin
        case (edli_pkg::cfg_reg_t'(cfg_index))
          edli_pkg::REG_CYCLES_PER_CM: per_cm    = cfg_data;
          edli_pkg::REG_HOLD_LIMIT:    hold_lim  = cfg_data[edli_pkg::HOLD_W-1:0];
          edli_pkg::REG_BLINK_CM:      blink_cm  = cfg_data;
          edli_pkg::REG_RED_CM:        red_cm    = cfg_data;
          edli_pkg::REG_YELLOW_CM:     yellow_cm = cfg_data;
          edli_pkg::REG_GREEN_CM:      green_cm  = cfg_data;
          edli_pkg::REG_CYAN_CM:       cyan_cm   = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) take_event(in_ch.func, in_ch.echo_level);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_reading();
    end
    readings_due <= due_q.size();
  end

endmodule

>>> test/tb_top.sv
// Testbench top: clock, reset, register phases, echo stimulus, result back-pressure and verdict
module tb_top;

  localparam int unsigned ITEM_BUDGET      = 1400;
  localparam int unsigned PHASES           = 10;
  localparam int unsigned PHASE_ITEMS      = ITEM_BUDGET / PHASES;
  localparam int unsigned SETTLE_CYCLES    = 40;
  localparam int unsigned HOLD_OFF_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT      = 400000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [edli_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [edli_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     mismatches;
  int unsigned                     readings_due;

  logic [edli_pkg::CFG_DATA_W-1:0] reg_plan [7];
  bit                              no_idle;
  int unsigned                     hold_off_req;
  int unsigned                     hold_off_done;
  logic                            echo_waiting;
  int unsigned                     items_sent;
  int unsigned                     last_ticks;
  int unsigned                     cycle_count = 0;

  edli_in_if  in_ch ();
  edli_out_if out_ch ();

  echo_distance_led_indicator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  edli_reading_checker reading_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .readings_due (readings_due)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, with a long hold-off on request
  initial begin
    int unsigned k;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_done != hold_off_req) begin
        hold_off_done = hold_off_req;
        out_ch.ready <= 1'b0;
        for (k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clk);
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 19);
        @(posedge clk);
      end
    end
  end

  // Offer one word, idling at random beforehand, and hold it until accepted
  task automatic send_word(input logic f, input logic lvl);
    while (!no_idle && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.echo_level <= lvl;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // Count only words the block acts on
    if (f == edli_pkg::FUNC_TICK) begin
      if (echo_waiting) items_sent++;
    end else if (lvl) begin
      echo_waiting = 1'b1;
      items_sent++;
    end else if (echo_waiting) begin
      echo_waiting = 1'b0;
      items_sent++;
    end
  endtask

  // One echo pulse lasting a given number of ticks
  task automatic measure_ticks(input int unsigned n);
    send_word(edli_pkg::FUNC_EDGE, 1'b1);
    repeat (n) send_word(edli_pkg::FUNC_TICK, 1'($urandom_range(0, 1)));
    send_word(edli_pkg::FUNC_EDGE, 1'b0);
  endtask

  // Drop valid and wait until every reading is in and the block has settled
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write every register from the plan, back to back
  task automatic write_regs();
    edli_pkg::cfg_reg_t r;
    r = r.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= reg_plan[r];
      @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed pulses, often within one tick of the last length; the rest is noise
  task automatic random_sequence(input int unsigned span);
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if ($urandom_range(0, 9) < 6)
        n = (last_ticks == 0) ? $urandom_range(0, 1) : last_ticks + $urandom_range(0, 2) - 1;
      else if ($urandom_range(0, 9) == 0)
        n = $urandom_range(0, 4 * span);
      else
        n = $urandom_range(0, span);
      last_ticks = n;
      measure_ticks(n);
    end else if (pick < 85) begin
      send_word(edli_pkg::FUNC_TICK, 1'($urandom_range(0, 1)));
    end else if (pick < 90) begin
      send_word(edli_pkg::FUNC_EDGE, 1'b0);
    end else if (pick < 95) begin
      // Rising edge while waiting restarts the count
      send_word(edli_pkg::FUNC_EDGE, 1'b1);
      repeat ($urandom_range(0, span))
        send_word(edli_pkg::FUNC_TICK, 1'($urandom_range(0, 1)));
      measure_ticks($urandom_range(0, span));
    end else begin
      send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned span;
    int unsigned mark;
    bit          paused;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= edli_pkg::FUNC_TICK;
    in_ch.echo_level <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= edli_pkg::REG_CYCLES_PER_CM;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    no_idle          = 1'b0;
    hold_off_req     = 0;
    hold_off_done    = 0;
    echo_waiting     = 1'b0;
    items_sent       = 0;
    last_ticks       = 0;
    paused           = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ignored words, zero-length pulse, restart, blink and red at reset settings
    send_word(edli_pkg::FUNC_EDGE, 1'b0);
    send_word(edli_pkg::FUNC_TICK, 1'b1);
    measure_ticks(0);
    send_word(edli_pkg::FUNC_EDGE, 1'b1);
    measure_ticks(0);
    measure_ticks(12);
    measure_ticks(22);

    for (phase = 0; phase < PHASES; phase++) begin
      span = 50;
      if (phase != 0) begin
        quiesce();
        case (phase)
          1: begin
            // Low extremes: unit divisor, no hold, all bands at zero
            reg_plan[edli_pkg::REG_CYCLES_PER_CM] = 12'd1;
            reg_plan[edli_pkg::REG_HOLD_LIMIT]    = 12'd0;
            reg_plan[edli_pkg::REG_BLINK_CM]      = 12'd0;
            reg_plan[edli_pkg::REG_RED_CM]        = 12'd0;
            reg_plan[edli_pkg::REG_YELLOW_CM]     = 12'd0;
            reg_plan[edli_pkg::REG_GREEN_CM]      = 12'd0;
            reg_plan[edli_pkg::REG_CYAN_CM]       = 12'd0;
            span = 20;
          end
          2: begin
            // High extremes
            reg_plan[edli_pkg::REG_CYCLES_PER_CM] = 12'd4095;
            reg_plan[edli_pkg::REG_HOLD_LIMIT]    = 12'd1023;
            reg_plan[edli_pkg::REG_BLINK_CM]      = 12'd4095;
            reg_plan[edli_pkg::REG_RED_CM]        = 12'd4095;
            reg_plan[edli_pkg::REG_YELLOW_CM]     = 12'd4095;
            reg_plan[edli_pkg::REG_GREEN_CM]      = 12'd4095;
            reg_plan[edli_pkg::REG_CYAN_CM]       = 12'd4095;
            span = 40;
          end
          3: begin
            // Zero divisor saturates the distance
            reg_plan[edli_pkg::REG_CYCLES_PER_CM] = 12'd0;
            reg_plan[edli_pkg::REG_HOLD_LIMIT]    = 12'($urandom_range(0, 3));
            reg_plan[edli_pkg::REG_BLINK_CM]      = 12'($urandom_range(0, 4095));
            reg_plan[edli_pkg::REG_RED_CM]        = 12'($urandom_range(0, 4095));
            reg_plan[edli_pkg::REG_YELLOW_CM]     = 12'($urandom_range(0, 4095));
            reg_plan[edli_pkg::REG_GREEN_CM]      = 12'($urandom_range(0, 4095));
            reg_plan[edli_pkg::REG_CYAN_CM]       = 12'($urandom_range(0, 4095));
            span = 10;
          end
          default: begin
            reg_plan[edli_pkg::REG_CYCLES_PER_CM] = 12'($urandom_range(32, 128));
            reg_plan[edli_pkg::REG_HOLD_LIMIT]    = ($urandom_range(0, 9) < 7) ?
                                                    12'($urandom_range(0, 6)) :
                                                    12'($urandom_range(0, 1023));
            if ($urandom_range(0, 1) == 0) begin
              // Ordered bands
              reg_plan[edli_pkg::REG_BLINK_CM]  = 12'($urandom_range(0, 20));
              reg_plan[edli_pkg::REG_RED_CM]    = reg_plan[edli_pkg::REG_BLINK_CM] +
                                                  12'($urandom_range(0, 30));
              reg_plan[edli_pkg::REG_YELLOW_CM] = reg_plan[edli_pkg::REG_RED_CM] +
                                                  12'($urandom_range(0, 60));
              reg_plan[edli_pkg::REG_GREEN_CM]  = reg_plan[edli_pkg::REG_YELLOW_CM] +
                                                  12'($urandom_range(0, 80));
              reg_plan[edli_pkg::REG_CYAN_CM]   = reg_plan[edli_pkg::REG_GREEN_CM] +
                                                  12'($urandom_range(0, 100));
            end else begin
              // Misordered bands
              reg_plan[edli_pkg::REG_BLINK_CM]  = 12'($urandom_range(0, 300));
              reg_plan[edli_pkg::REG_RED_CM]    = 12'($urandom_range(0, 300));
              reg_plan[edli_pkg::REG_YELLOW_CM] = 12'($urandom_range(0, 300));
              reg_plan[edli_pkg::REG_GREEN_CM]  = 12'($urandom_range(0, 300));
              reg_plan[edli_pkg::REG_CYAN_CM]   = 12'($urandom_range(0, 300));
            end
          end
        endcase
        write_regs();
      end else begin
        span = 60;
      end

      // Long receiver hold-off while words keep coming
      if (phase == 4) hold_off_req++;
      no_idle = (phase == 6);

      mark = items_sent;
      while (items_sent - mark < PHASE_ITEMS) begin
        if (phase == 5 && !paused && items_sent - mark >= PHASE_ITEMS / 2) begin
          quiesce();
          paused = 1'b1;
        end
        random_sequence(span);
      end
    end

    quiesce();
    if (mismatches == 0 && readings_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
